// ===== sv/nbse_pkg.sv =====
package nbse_pkg;

  // Field widths fixed by the item and register formats.
  localparam int CLASS_W    = 4;
  localparam int FEAT_W     = 6;
  localparam int WORD_W     = 32;
  localparam int ACC_W      = 48;
  localparam int POS_W      = 7;
  localparam int MODE_W     = 2;
  localparam int OPC_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SUM_W      = 52;
  localparam int TERM_W     = 51;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OPC_W-1:0] OPC_LOAD_TERM  = 2'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD_PRIOR = 2'd1;
  localparam logic [OPC_W-1:0] OPC_FEATURE    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MULTI = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BERN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd1;

  localparam logic [POS_W-1:0] POS_MAX           = 7'd127;
  localparam logic [POS_W-1:0] FEATURE_COUNT_RST = 7'd64;

  localparam logic signed [WORD_W-1:0] BERN_HALF = 32'sh0000_8000;
  localparam logic signed [ACC_W-1:0]  ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [48:0]              Q_CLAMP   = {1'b1, 48'd0};

  typedef enum logic [1:0] {
    CMD_TERM,
    CMD_PRIOR,
    CMD_FEATURE
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [CLASS_W-1:0]       class_index;
    logic [FEAT_W-1:0]        feature_index;
    logic [POS_W-1:0]         position;
    logic                     active;
    logic                     last;
    logic signed [WORD_W-1:0] term_a;
    logic signed [WORD_W-1:0] term_b;
    logic signed [WORD_W-1:0] term_c;
    logic signed [WORD_W-1:0] feature_value;
  } entry_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > SUM_W'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (v < SUM_W'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/nbse_fifo.sv =====
module nbse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/nbse_front.sv =====
module nbse_front
  import nbse_pkg::*;
#(
  parameter int NUM_CLASSES  = 16,
  parameter int MAX_FEATURES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPC_W-1:0]         in_opcode,
  input  logic [CLASS_W-1:0]       in_class_index,
  input  logic [FEAT_W-1:0]        in_feature_index,
  input  logic signed [WORD_W-1:0] in_term_a,
  input  logic signed [WORD_W-1:0] in_term_b,
  input  logic signed [WORD_W-1:0] in_term_c,
  input  logic signed [WORD_W-1:0] in_feature_value,
  input  logic                     in_last_feature,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     q_full,
  output logic                     q_push,
  output entry_t                   q_entry,
  output logic [MODE_W-1:0]        mode
);

  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  count_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              take;
  logic              class_ok;
  logic              feat_ok;
  logic              active;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign take      = in_valid && !q_full;
  assign mode      = mode_r;

  assign class_ok = (int'(in_class_index) < NUM_CLASSES);
  assign feat_ok  = (int'(in_feature_index) < MAX_FEATURES);
  assign active   = (pos_r < count_r) && (int'(pos_r) < MAX_FEATURES) && (mode_r <= MODE_BERN);

  always_comb begin
    q_entry.cmd           = CMD_FEATURE;
    q_entry.class_index   = in_class_index;
    q_entry.feature_index = in_feature_index;
    q_entry.position      = pos_r;
    q_entry.active        = active;
    q_entry.last          = in_last_feature;
    q_entry.term_a        = in_term_a;
    q_entry.term_b        = in_term_b;
    q_entry.term_c        = in_term_c;
    q_entry.feature_value = in_feature_value;
    q_push                = 1'b0;
    pos_nxt               = pos_r;
    unique case (in_opcode)
      OPC_LOAD_TERM: begin
        q_entry.cmd = CMD_TERM;
        q_push      = take && class_ok && feat_ok;
      end
      OPC_LOAD_PRIOR: begin
        q_entry.cmd = CMD_PRIOR;
        q_push      = take && class_ok;
      end
      OPC_FEATURE: begin
        q_push = take;
        if (take) begin
          if (in_last_feature) begin
            pos_nxt = '0;
          end else if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_GAUSS;
      count_r <= FEATURE_COUNT_RST;
      pos_r   <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_MODEL_MODE) begin
          mode_r <= cfg_data[MODE_W-1:0];
        end else if (cfg_index == CFG_FEATURE_COUNT) begin
          count_r <= cfg_data[POS_W-1:0];
        end
      end
    end
  end

endmodule

// ===== sv/nbse_back.sv =====
module nbse_back
  import nbse_pkg::*;
#(
  parameter int NUM_CLASSES  = 16,
  parameter int MAX_FEATURES = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  entry_t                  q_entry,
  output logic                    q_pop,
  input  logic [MODE_W-1:0]       mode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CLASS_W-1:0]      out_best_class,
  output logic                    out_class_found,
  output logic signed [ACC_W-1:0] out_best_score
);

  localparam int CIDX_W    = $clog2(NUM_CLASSES);
  localparam int TBL_DEPTH = NUM_CLASSES * MAX_FEATURES;
  localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int ROW_W     = 3 * WORD_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN} state_t;

  state_t                   state_r;
  logic [CIDX_W-1:0]        k_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     item_active_r;
  logic                     item_last_r;
  logic signed [WORD_W-1:0] item_x_r;
  logic                     out_valid_r;
  logic [CLASS_W-1:0]       out_best_class_r;
  logic                     out_class_found_r;
  logic signed [ACC_W-1:0]  out_best_score_r;

  // Memories
  logic [ROW_W-1:0]         tbl_mem [TBL_DEPTH];
  logic signed [WORD_W-1:0] prior_mem [NUM_CLASSES];
  logic signed [ACC_W-1:0]  acc_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]   acc_vld_r;
  logic [NUM_CLASSES-1:0]   present_r;

  logic              issue;
  logic              start;
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  logic              prior_we;
  logic [CIDX_W-1:0] load_class;
  logic              pipe_busy;
  logic              fire;

  // Pipeline registers
  logic                     v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [CIDX_W-1:0]        k1_r, k2_r, k3_r, k4_r, k5_r, k6_r;
  logic [ROW_W-1:0]         row_q;
  logic [WORD_W-1:0]        s2_opa_r, s2_opb_r, s2_mb_r;
  logic                     s2_bneg_r, s2_mneg_r;
  logic signed [WORD_W-1:0] s2_tc_r, s2_bern_r;
  logic [63:0]              s3_prod_r;
  logic [WORD_W-1:0]        s3_mb_r;
  logic                     s3_bneg_r, s3_mneg_r;
  logic signed [WORD_W-1:0] s3_tc_r, s3_bern_r;
  logic [63:0]              s4_prod_r;
  logic [55:0]              s4_phi_r;
  logic [WORD_W-1:0]        s4_mb_r;
  logic                     s4_bneg_r, s4_mneg_r;
  logic signed [WORD_W-1:0] s4_tc_r, s4_bern_r;
  logic [63:0]              s5_prod_r;
  logic [55:0]              s5_phi_r, s5_plo_r;
  logic                     s5_bneg_r, s5_mneg_r;
  logic signed [WORD_W-1:0] s5_tc_r, s5_bern_r;
  logic signed [TERM_W-1:0] s6_term_r;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     accv_q;
  logic signed [WORD_W-1:0] prior_q;

  logic                     found_r;
  logic [CIDX_W-1:0]        best_r;
  logic signed [ACC_W-1:0]  best_s_r;
  logic                     found_nxt;
  logic [CIDX_W-1:0]        best_nxt;
  logic signed [ACC_W-1:0]  best_s_nxt;

  // Sequencer
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r || v5_r || v6_r;
  assign issue     = (state_r == ST_SWEEP);
  assign load_class = CIDX_W'(q_entry.class_index);
  assign tbl_waddr  = ADDR_W'(q_entry.class_index) * ADDR_W'(MAX_FEATURES)
                    + ADDR_W'(q_entry.feature_index);

  always_comb begin
    q_pop    = 1'b0;
    start    = 1'b0;
    tbl_we   = 1'b0;
    prior_we = 1'b0;
    if (state_r == ST_IDLE && !q_empty) begin
      case (q_entry.cmd)
        CMD_TERM: begin
          q_pop  = 1'b1;
          tbl_we = 1'b1;
        end
        CMD_PRIOR: begin
          q_pop    = 1'b1;
          prior_we = 1'b1;
        end
        CMD_FEATURE: begin
          if (!(q_entry.last && out_valid_r)) begin
            q_pop = 1'b1;
            start = 1'b1;
          end
        end
        default: begin
          q_pop = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      k_r               <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r       <= ST_SWEEP;
            k_r           <= '0;
            addr_r        <= q_entry.active ? ADDR_W'(q_entry.position) : '0;
            item_active_r <= q_entry.active;
            item_last_r   <= q_entry.last;
            item_x_r      <= q_entry.feature_value;
          end
        end
        ST_SWEEP: begin
          k_r <= k_r + 1'b1;
          if (item_active_r) begin
            addr_r <= addr_r + ADDR_W'(MAX_FEATURES);
          end
          if (k_r == CIDX_W'(NUM_CLASSES - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (fire) begin
        out_valid_r       <= 1'b1;
        out_best_class_r  <= CLASS_W'(best_nxt);
        out_class_found_r <= found_nxt;
        out_best_score_r  <= best_s_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_class  = out_best_class_r;
  assign out_class_found = out_class_found_r;
  assign out_best_score  = out_best_score_r;

  // Term table: one row per class and feature.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= {q_entry.term_a, q_entry.term_b, q_entry.term_c};
    end
    row_q <= tbl_mem[addr_r];
  end

  // Priors and accumulators are read with the stage 5 class index and registered for the add.
  always_ff @(posedge clk) begin
    if (prior_we) begin
      prior_mem[load_class] <= q_entry.term_a;
    end
    prior_q <= prior_mem[k5_r];
  end

  logic signed [ACC_W-1:0] acc_new;

  always_ff @(posedge clk) begin
    if (v6_r) begin
      acc_mem[k6_r] <= acc_new;
    end
    acc_q <= acc_mem[k5_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
      present_r <= '0;
      accv_q    <= 1'b0;
    end else begin
      accv_q <= acc_vld_r[k5_r];
      if (v6_r) begin
        acc_vld_r[k6_r] <= !item_last_r;
      end
      if (prior_we) begin
        present_r[load_class] <= 1'b1;
      end
    end
  end

  // Stage 1: operand selection from the table row.
  logic signed [WORD_W-1:0] ta, tb, tc;
  logic signed [WORD_W:0]   diff, diff_abs, ta_abs, tb_abs;

  assign ta       = row_q[3*WORD_W-1:2*WORD_W];
  assign tb       = row_q[2*WORD_W-1:WORD_W];
  assign tc       = row_q[WORD_W-1:0];
  assign diff     = (WORD_W+1)'(item_x_r) - (WORD_W+1)'(ta);
  assign diff_abs = diff[WORD_W] ? -diff : diff;
  assign ta_abs   = ta[WORD_W-1] ? -(WORD_W+1)'(ta) : (WORD_W+1)'(ta);
  assign tb_abs   = tb[WORD_W-1] ? -(WORD_W+1)'(tb) : (WORD_W+1)'(tb);

  // Stage 5: assemble the per-class term.
  logic [64:0]              q_full;
  logic [48:0]              q_sat;
  logic signed [TERM_W-1:0] term_gauss;
  logic [64:0]              up_sum;
  logic signed [TERM_W-1:0] term_multi;
  logic signed [TERM_W-1:0] term_sel;

  assign q_full     = {1'b0, s5_phi_r, 8'd0} + {25'd0, s5_plo_r[55:16]};
  assign q_sat      = (q_full > 65'(Q_CLAMP)) ? Q_CLAMP : q_full[48:0];
  assign term_gauss = s5_bneg_r ? TERM_W'(s5_tc_r) + TERM_W'(q_sat)
                                : TERM_W'(s5_tc_r) - TERM_W'(q_sat);
  assign up_sum     = {1'b0, s5_prod_r} + 65'd65535;
  assign term_multi = s5_mneg_r ? -TERM_W'(up_sum[64:16]) : TERM_W'(s5_prod_r[63:16]);

  always_comb begin
    case (mode)
      MODE_GAUSS: term_sel = term_gauss;
      MODE_MULTI: term_sel = term_multi;
      default:    term_sel = TERM_W'(s5_bern_r);
    endcase
  end

  // Stage 6: accumulate and track the running maximum.
  logic signed [ACC_W-1:0] acc_cur;
  logic signed [ACC_W-1:0] score;
  logic                    upd;

  assign acc_cur = accv_q ? acc_q : '0;
  assign upd     = item_active_r && present_r[k6_r];
  assign acc_new = upd ? sat_acc(SUM_W'(acc_cur) + SUM_W'(s6_term_r)) : acc_cur;
  assign score   = sat_acc(SUM_W'(acc_new) + SUM_W'(prior_q));
  assign fire    = v6_r && item_last_r && (k6_r == CIDX_W'(NUM_CLASSES - 1));

  always_comb begin
    found_nxt  = found_r;
    best_nxt   = best_r;
    best_s_nxt = best_s_r;
    if (v6_r && present_r[k6_r] && (!found_r || score > best_s_r)) begin
      found_nxt  = 1'b1;
      best_nxt   = k6_r;
      best_s_nxt = score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      found_r  <= 1'b0;
      best_r   <= '0;
      best_s_r <= '0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      if (start) begin
        found_r  <= 1'b0;
        best_r   <= '0;
        best_s_r <= '0;
      end else begin
        found_r  <= found_nxt;
        best_r   <= best_nxt;
        best_s_r <= best_s_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    k1_r <= k_r;
    k2_r <= k1_r;
    k3_r <= k2_r;
    k4_r <= k3_r;
    k5_r <= k4_r;
    k6_r <= k5_r;

    if (mode == MODE_MULTI) begin
      s2_opa_r <= ta_abs[WORD_W-1:0];
      s2_opb_r <= (item_x_r > 0) ? item_x_r : '0;
    end else begin
      s2_opa_r <= diff_abs[WORD_W-1:0];
      s2_opb_r <= diff_abs[WORD_W-1:0];
    end
    s2_mb_r   <= tb_abs[WORD_W-1:0];
    s2_bneg_r <= tb[WORD_W-1];
    s2_mneg_r <= ta[WORD_W-1];
    s2_tc_r   <= tc;
    s2_bern_r <= (item_x_r > BERN_HALF) ? ta : tb;

    s3_prod_r <= 64'(s2_opa_r) * 64'(s2_opb_r);
    s3_mb_r   <= s2_mb_r;
    s3_bneg_r <= s2_bneg_r;
    s3_mneg_r <= s2_mneg_r;
    s3_tc_r   <= s2_tc_r;
    s3_bern_r <= s2_bern_r;

    // The square is taken down by 16 bits, then split into 24-bit halves.
    s4_phi_r  <= 56'(s3_prod_r[63:40]) * 56'(s3_mb_r);
    s4_prod_r <= s3_prod_r;
    s4_mb_r   <= s3_mb_r;
    s4_bneg_r <= s3_bneg_r;
    s4_mneg_r <= s3_mneg_r;
    s4_tc_r   <= s3_tc_r;
    s4_bern_r <= s3_bern_r;

    s5_plo_r  <= 56'(s4_prod_r[39:16]) * 56'(s4_mb_r);
    s5_phi_r  <= s4_phi_r;
    s5_prod_r <= s4_prod_r;
    s5_bneg_r <= s4_bneg_r;
    s5_mneg_r <= s4_mneg_r;
    s5_tc_r   <= s4_tc_r;
    s5_bern_r <= s4_bern_r;

    s6_term_r <= term_sel;
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pipe_busy)
    else $error("class pipeline busy while sequencer idle");

  a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !out_valid_r)
    else $error("result produced while output register occupied");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && !v6_r))
    else $error("queue popped while a sweep is in flight");

endmodule

// ===== sv/naive_bayes_scoring_engine.sv =====
// Channel | Direction | Ports                                       | Handshake
// in      | input     | in_opcode .. in_last_feature (8 fields)     | in_valid / in_ready
// out     | output    | out_best_class, out_class_found, out_best_score | out_valid / out_ready
// cfg     | input     | cfg_index, cfg_data                         | cfg_valid / cfg_ready
//
// A feature beat sweeps all classes, one class per cycle through the table/multiply/accumulate
// pipe, then drains. The sweep length is set by the single read port of the term table. Reset is
// synchronous and active low; it clears presence flags, accumulator valid flags and the position.
// The two-entry queue accepts beats while not full, also while a sweep runs or a result waits.
module naive_bayes_scoring_engine
  import nbse_pkg::*;
#(
  parameter int NUM_CLASSES  = 16,
  parameter int MAX_FEATURES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPC_W-1:0]         in_opcode,
  input  logic [CLASS_W-1:0]       in_class_index,
  input  logic [FEAT_W-1:0]        in_feature_index,
  input  logic signed [WORD_W-1:0] in_term_a,
  input  logic signed [WORD_W-1:0] in_term_b,
  input  logic signed [WORD_W-1:0] in_term_c,
  input  logic signed [WORD_W-1:0] in_feature_value,
  input  logic                     in_last_feature,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CLASS_W-1:0]       out_best_class,
  output logic                     out_class_found,
  output logic signed [ACC_W-1:0]  out_best_score,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  // The front end decodes each beat, drops loads that fall outside the tables, and stamps
  // feature beats with their position and whether they still count toward the score.
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  entry_t            push_entry;
  entry_t            pop_entry;
  logic [MODE_W-1:0] mode;

  nbse_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_class_index  (in_class_index),
    .in_feature_index(in_feature_index),
    .in_term_a       (in_term_a),
    .in_term_b       (in_term_b),
    .in_term_c       (in_term_c),
    .in_feature_value(in_feature_value),
    .in_last_feature (in_last_feature),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (push_entry),
    .mode            (mode)
  );

  // Decoded beats wait here; the front end stalls on a running sweep only once the queue is full.
  nbse_fifo #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_entry),
    .pop      (q_pop),
    .pop_data (pop_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back end owns the tables, the accumulators and the result register.
  nbse_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .mode           (mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_class (out_best_class),
    .out_class_found(out_class_found),
    .out_best_score (out_best_score)
  );

endmodule
